[sv/psbd_pkg.sv]
// Shared types and constants for the persistent signal band detector.
// No dependencies; every other file of the block but psbd_ram imports this package.
`default_nettype none

package psbd_pkg;

	// Fixed field widths
	localparam int BIN_W   = 10;
	localparam int DB_W    = 16;
	localparam int CNT_W   = 4;
	localparam int CFG_DW  = 32;
	localparam int CFG_AW  = 3;

	// Configuration register selects, as the value of paddr[2]
	localparam logic REG_THRESHOLD   = 1'b0;
	localparam logic REG_PERSISTENCE = 1'b1;

	localparam logic signed [DB_W-1:0] THRESHOLD_RST   = '0;
	localparam logic [CNT_W-1:0]       PERSISTENCE_RST = 4'd3;

	// Front/back queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Item classes as decided by the front
	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_SKIP,
		KIND_RESTART
	} item_kind_t;

	typedef struct packed {
		item_kind_t       kind;
		logic [BIN_W-1:0] bin;
		logic             above;
	} item_t;

	typedef struct packed {
		logic signed [DB_W-1:0] threshold;
		logic [CNT_W-1:0]       persistence;
	} cfg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_CLEAR
	} back_state_t;

endpackage

`default_nettype wire

[sv/psbd_if.sv]
// Valid/ready channel interfaces for the band detector's request and result sides.
// Depends on psbd_pkg for field widths.
`default_nettype none

interface psbd_in_if import psbd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic [BIN_W-1:0]       bin_index;
	logic signed [DB_W-1:0] db_value;

	modport source (output valid, output operation, output bin_index, output db_value,
		input ready);
	modport sink (input valid, input operation, input bin_index, input db_value,
		output ready);
endinterface

interface psbd_out_if import psbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             band_found;
	logic [BIN_W-1:0] band_low_bin;
	logic [BIN_W-1:0] band_high_bin;

	modport source (output valid, output band_found, output band_low_bin,
		output band_high_bin, input ready);
	modport sink (input valid, input band_found, input band_low_bin,
		input band_high_bin, output ready);
endinterface

`default_nettype wire

[sv/psbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psbd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/psbd_front.sv]
// Front end: accepts requests and classifies them as sample, skip or restart.
// Depends on psbd_pkg and psbd_in_if.
`default_nettype none

module psbd_front import psbd_pkg::*; #(
	parameter int NUM_BINS = 1024
) (
	psbd_in_if.sink   in_ch,
	input  cfg_t      cfg,
	input  wire logic q_full,
	input  wire logic clearing,
	output logic      push,
	output item_t     item
);

	logic in_range;

	// Hold off while the queue is full or the counter store is being swept
	assign in_ch.ready = !q_full && !clearing;
	assign push        = in_ch.valid && in_ch.ready;

	assign in_range = 17'(in_ch.bin_index) < 17'(NUM_BINS);

	always_comb begin
		item.bin   = in_ch.bin_index;
		item.above = $signed(in_ch.db_value) > $signed(cfg.threshold);
		priority if (in_ch.operation) begin
			item.kind = KIND_RESTART;
		end else if (!in_range) begin
			item.kind = KIND_SKIP;
		end else begin
			item.kind = KIND_SAMPLE;
		end
	end

endmodule

`default_nettype wire

[sv/psbd_queue.sv]
// Short FIFO of classified requests between the front and back ends.
// Depends on psbd_pkg.
`default_nettype none

module psbd_queue import psbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_item,
	input  wire logic pop,
	output logic      q_valid,
	output logic      q_full,
	output item_t     q_item
);

	item_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign q_item  = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[sv/psbd_back.sv]
// Back end: counter read-modify-write, band tracking, clearing sweep, result register.
// Depends on psbd_pkg, psbd_out_if and psbd_ram.
`default_nettype none

module psbd_back import psbd_pkg::*; #(
	parameter int NUM_BINS = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	input  wire logic  q_valid,
	input  item_t      q_item,
	output logic       pop,
	output logic       clearing,
	psbd_out_if.source out_ch
);

	localparam int                AW   = $clog2(NUM_BINS);
	localparam logic [AW-1:0]     LAST = AW'(NUM_BINS - 1);

	back_state_t      state_q, state_d;
	logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
	item_t            cur_s1;
	logic             found_q, found_d;
	logic [BIN_W-1:0] low_q, low_d;
	logic [BIN_W-1:0] high_q, high_d;
	logic             out_valid_q;
	logic             out_found_q;
	logic [BIN_W-1:0] out_low_q, out_high_q;

	logic             out_free;
	logic             out_load;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [CNT_W-1:0] ram_rdata;
	logic [CNT_W-1:0] cnt_inc;
	logic             hit;

	assign out_free = !out_valid_q || out_ch.ready;
	assign clearing = state_q == B_CLEAR;
	assign cnt_inc  = ram_rdata + 1'b1;
	assign hit      = cur_s1.above && (ram_rdata < cfg.persistence);

	psbd_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_BINS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(AW'(q_item.bin)),
		.rdata(ram_rdata)
	);

	// State, sweep counter, band and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_cnt_q   <= '0;
			found_q     <= 1'b0;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= clr_cnt_d;
			found_q   <= found_d;
			low_q     <= low_d;
			high_q    <= high_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_s1 <= q_item;
		end
		if (out_load) begin
			out_found_q <= found_d;
			out_low_q   <= found_d ? low_d : '0;
			out_high_q  <= found_d ? high_d : '0;
		end
	end

	// Next state, RAM control and band update
	always_comb begin
		state_d   = state_q;
		clr_cnt_d = clr_cnt_q;
		found_d   = found_q;
		low_d     = low_q;
		high_d    = high_q;
		pop       = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		unique case (state_q)
			B_CLEAR: begin
				ram_we = 1'b1;
				if (clr_cnt_q == LAST) begin
					clr_cnt_d = '0;
					state_d   = B_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			B_IDLE: begin
				if (q_valid && out_free) begin
					pop = 1'b1;
					unique case (q_item.kind)
						KIND_SAMPLE: begin
							// RAM read of the counter is in flight
							state_d = B_READ;
						end
						KIND_RESTART: begin
							found_d  = 1'b0;
							low_d    = '0;
							high_d   = '0;
							out_load = 1'b1;
							state_d  = B_CLEAR;
						end
						default: begin
							// out of range bin: report the band unchanged
							out_load = 1'b1;
						end
					endcase
				end
			end
			B_READ: begin
				out_load = 1'b1;
				state_d  = B_IDLE;
				if (hit) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(cur_s1.bin);
					ram_wdata = cnt_inc;
					// bin joins the band when its count first reaches the limit
					if (cnt_inc == cfg.persistence) begin
						found_d = 1'b1;
						if (!found_q) begin
							low_d  = cur_s1.bin;
							high_d = cur_s1.bin;
						end else begin
							if (cur_s1.bin < low_q) begin
								low_d = cur_s1.bin;
							end
							if (cur_s1.bin > high_q) begin
								high_d = cur_s1.bin;
							end
						end
					end
				end
			end
			default: begin
				state_d = B_CLEAR;
			end
		endcase
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.band_found    = out_found_q;
	assign out_ch.band_low_bin  = out_low_q;
	assign out_ch.band_high_bin = out_high_q;

endmodule

`default_nettype wire

[sv/persistent_signal_band_detector.sv]
// Channel        Dir  Handshake    Payload
// in_ch          in   valid/ready  operation, bin_index[9:0], db_value[15:0] (signed Q8.8)
// out_ch         out  valid/ready  band_found, band_low_bin[9:0], band_high_bin[9:0]
// APB cfg        in   psel/penable threshold_db @0x0, persistence_count @0x4
//
// A sample for an in-range bin is handled in B_IDLE (counter RAM read), then in B_READ
// (write and result); an out-of-range sample gets its result in B_IDLE. A restart loads
// its result, then the B_CLEAR sweep zeroes the counter RAM one entry per cycle; in_ch.ready
// is low during it. After reset the same sweep runs before the first request is taken.
// A 2-entry queue separates front and back; the back end takes the next request only when
// the result register is empty or being taken on out_ch.ready, so a stalled result stalls it.
// Depends on psbd_pkg, psbd_if, psbd_front, psbd_queue, psbd_back.
`default_nettype none

module persistent_signal_band_detector import psbd_pkg::*; #(
	parameter int NUM_BINS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	psbd_in_if.sink                in_ch,
	psbd_out_if.source             out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_valid;
	logic  q_full;
	item_t q_item;
	logic  clearing;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THRESHOLD_RST;
			cfg_q.persistence <= PERSISTENCE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_THRESHOLD:   cfg_q.threshold   <= pwdata[DB_W-1:0];
				REG_PERSISTENCE: cfg_q.persistence <= pwdata[CNT_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD:   prdata = CFG_DW'(cfg_q.threshold);
			REG_PERSISTENCE: prdata = CFG_DW'(cfg_q.persistence);
			default:         prdata = '0;
		endcase
	end

	psbd_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.in_ch   (in_ch),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.clearing(clearing),
		.push    (push),
		.item    (push_item)
	);

	psbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.q_item   (q_item)
	);

	psbd_back #(
		.NUM_BINS(NUM_BINS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.clearing(clearing),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

[sv/psbd_checker.sv]
// Port-level checks on the result channel of the band detector, bound to the top level.
// Depends on psbd_pkg and persistent_signal_band_detector.
`default_nettype none

module psbd_checker import psbd_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             band_found,
	input wire logic [BIN_W-1:0] band_low_bin,
	input wire logic [BIN_W-1:0] band_high_bin
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(band_found) && $stable(band_low_bin) && $stable(band_high_bin))
		else $error("result payload changed while stalled");

	// Without a band the band fields read zero
	a_no_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !band_found |->
			(band_low_bin == '0) && (band_high_bin == '0))
		else $error("band fields nonzero with no band");

	// A found band is ordered
	a_band_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && band_found |-> band_low_bin <= band_high_bin)
		else $error("band low above band high");

endmodule

bind persistent_signal_band_detector psbd_checker u_psbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.band_found   (out_ch.band_found),
	.band_low_bin (out_ch.band_low_bin),
	.band_high_bin(out_ch.band_high_bin)
);

`default_nettype wire

[tb/persistent_signal_band_detector_tb.sv]
// Self-checking bench for persistent_signal_band_detector: drives bin samples and restarts
// over valid/ready channels, programs both registers over APB and checks every band result.
// Depends on psbd_pkg, psbd_if and the detector RTL.
`default_nettype none

module persistent_signal_band_detector_tb import psbd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BINS       = 1024;
	localparam int IDLE_PCT   = 29;
	localparam int PHASE_REQS = 225;
	localparam int CYCLE_CAP  = 500000;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [CFG_AW-1:0] ADDR_THRESHOLD   = {REG_THRESHOLD, 2'b00};
	localparam logic [CFG_AW-1:0] ADDR_PERSISTENCE = {REG_PERSISTENCE, 2'b00};

	typedef struct packed {
		logic             found;
		logic [BIN_W-1:0] low;
		logic [BIN_W-1:0] high;
	} band_t;

	// Mirror of the detector: per-bin counters, band edges and the live register values
	class band_track;
		logic signed [DB_W-1:0] threshold;
		logic [CNT_W-1:0]       persistence;
		logic [CNT_W-1:0]       counts [BINS];
		logic                   found;
		logic [BIN_W-1:0]       low;
		logic [BIN_W-1:0]       high;
		band_t                  pending_bands [$];
		int                     mismatches;

		function new();
			threshold   = THRESHOLD_RST;
			persistence = PERSISTENCE_RST;
			mismatches  = 0;
			clear_band();
		endfunction

		function void clear_band();
			foreach (counts[i])
				counts[i] = '0;
			found = 1'b0;
			low   = '0;
			high  = '0;
		endfunction

		// Apply one accepted request and queue the band it should report
		function void note_request(input logic op, input logic [BIN_W-1:0] bin,
				input logic signed [DB_W-1:0] db);
			logic [CNT_W-1:0] c;
			band_t            b;
			if (op == OP_RESTART) begin
				clear_band();
			end else if (bin < BINS) begin
				c = counts[bin];
				if (db > threshold && c < persistence) begin
					c = c + 1'b1;
					counts[bin] = c;
					// first arrival at the limit joins the band
					if (c == persistence) begin
						if (!found) begin
							low   = bin;
							high  = bin;
							found = 1'b1;
						end else begin
							if (bin < low)
								low = bin;
							if (bin > high)
								high = bin;
						end
					end
				end
			end
			b.found = found;
			b.low   = found ? low : '0;
			b.high  = found ? high : '0;
			pending_bands = {pending_bands, b};
		endfunction

		function void check_band(input logic f, input logic [BIN_W-1:0] lo,
				input logic [BIN_W-1:0] hi);
			band_t want;
			if (pending_bands.size() == 0) begin
				$error("band result with no request pending");
				mismatches++;
				return;
			end
			want = pending_bands.pop_front();
			if (f !== want.found) begin
				$error("band_found: expected %0d, got %0d", want.found, f);
				mismatches++;
			end
			if (lo !== want.low) begin
				$error("band_low_bin: expected %0d, got %0d", want.low, lo);
				mismatches++;
			end
			if (hi !== want.high) begin
				$error("band_high_bin: expected %0d, got %0d", want.high, hi);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	wire  [CFG_DW-1:0] prdata;
	wire               pready;

	psbd_in_if  in_ch ();
	psbd_out_if out_ch ();

	band_track sb;
	bit        steady_run;
	int        cycle_count;

	persistent_signal_band_detector #(
		.NUM_BINS(BINS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side: random back-pressure, checked at the rising edge
	always @(negedge clk) begin
		out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_band(out_ch.band_found, out_ch.band_low_bin, out_ch.band_high_bin);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("persistent_signal_band_detector_tb NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance, valid left high
	task automatic send_req(input logic op, input logic [BIN_W-1:0] bin,
			input logic signed [DB_W-1:0] db);
		while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.bin_index <= bin;
		in_ch.db_value  <= db;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_request(op, bin, db);
		@(negedge clk);
	endtask

	task automatic quiet_sender();
		in_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Write one register, then read it back on the combinational read path
	task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		if (prdata !== data) begin
			$error("prdata: expected %0h, got %0h", data, prdata);
			sb.mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Drain, let any restart sweep finish, then program both registers
	task automatic configure(input logic signed [DB_W-1:0] thr, input logic [CNT_W-1:0] pers);
		while (sb.pending_bands.size() != 0)
			@(posedge clk);
		repeat (BINS + 8) @(posedge clk);
		@(negedge clk);
		write_reg(ADDR_THRESHOLD, {{(CFG_DW-DB_W){thr[DB_W-1]}}, thr});
		write_reg(ADDR_PERSISTENCE, {{(CFG_DW-CNT_W){1'b0}}, pers});
		sb.threshold   = thr;
		sb.persistence = pers;
	endtask

	// Mostly just above the threshold, sometimes equal, sometimes anything
	function automatic logic signed [DB_W-1:0] pick_level(input logic signed [DB_W-1:0] thr);
		int r;
		int lvl;
		r = $urandom_range(99);
		if (r < 20)
			return DB_W'($urandom);
		if (r < 25)
			return thr;
		lvl = int'(thr) + 1 + int'($urandom_range(0, 3000));
		if (lvl > 32767)
			lvl = 32767;
		return DB_W'(lvl);
	endfunction

	function automatic logic signed [DB_W-1:0] rand_threshold();
		return DB_W'(int'($urandom_range(0, 32767)) - 16384);
	endfunction

	// A handful of hot bins hit repeatedly so counters climb, with stray samples and restarts
	task automatic random_phase(input bit lead_restart);
		logic [BIN_W-1:0] hot [6];
		int               r;
		foreach (hot[k]) begin
			r = $urandom_range(9);
			if (r == 0)
				hot[k] = '0;
			else if (r == 1)
				hot[k] = BIN_W'(BINS - 1);
			else
				hot[k] = BIN_W'($urandom_range(0, BINS - 1));
		end
		if (lead_restart)
			send_req(OP_RESTART, BIN_W'($urandom), DB_W'($urandom));
		for (int i = 0; i < PHASE_REQS; i++) begin
			r = $urandom_range(99);
			if (r == 0)
				send_req(OP_RESTART, BIN_W'($urandom), DB_W'($urandom));
			else if (r < 86)
				send_req(OP_SAMPLE, hot[$urandom_range(0, 5)], pick_level(sb.threshold));
			else
				send_req(OP_SAMPLE, BIN_W'($urandom), DB_W'($urandom));
		end
		quiet_sender();
	endtask

	initial begin
		logic signed [DB_W-1:0] thr_plan  [8];
		logic [CNT_W-1:0]       pers_plan [8];

		sb              = new();
		steady_run      = 1'b0;
		cycle_count     = 0;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.operation = OP_SAMPLE;
		in_ch.bin_index = '0;
		in_ch.db_value  = '0;
		out_ch.ready    = 1'b0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: single-hit persistence, edge bins, threshold equality, restart
		configure(16'sd0, 4'd1);
		send_req(OP_SAMPLE, 10'd0, 16'sh7FFF);
		send_req(OP_SAMPLE, 10'd1023, 16'sd1);
		send_req(OP_SAMPLE, 10'd512, 16'sd0);
		send_req(OP_SAMPLE, 10'd512, 16'sh8000);
		send_req(OP_RESTART, 10'd1023, 16'sh7FFF);
		send_req(OP_SAMPLE, 10'd700, 16'sh0100);
		send_req(OP_SAMPLE, 10'd300, 16'sd5);
		quiet_sender();

		// Directed: lowest threshold, longest persistence, then saturation
		configure(16'sh8000, 4'd15);
		send_req(OP_RESTART, 10'd0, 16'sd0);
		repeat (16) send_req(OP_SAMPLE, 10'd5, -16'sd32767);
		quiet_sender();

		// Directed: highest threshold, limit lowered under a saturated counter
		configure(16'sd32767, 4'd2);
		send_req(OP_SAMPLE, 10'd5, 16'sd32767);
		quiet_sender();

		// Random phases; zero persistence and a lowered limit keep the old counters
		thr_plan  = '{rand_threshold(), 16'sh8000, rand_threshold(), 16'sd32767,
			rand_threshold(), rand_threshold(), rand_threshold(), rand_threshold()};
		pers_plan = '{4'd3, 4'd1, 4'd15, 4'd4, 4'd0, 4'd8, 4'd2, 4'd5};
		for (int p = 0; p < 8; p++) begin
			configure(thr_plan[p], pers_plan[p]);
			steady_run = (p == 2);
			random_phase((p != 4) && (p != 6) && ($urandom_range(1) == 1));
			steady_run = 1'b0;
		end

		while (sb.pending_bands.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("persistent_signal_band_detector_tb OK");
		else
			$display("persistent_signal_band_detector_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
